### hdl/lsld_pkg.sv
`timescale 1ns / 1ps

package lsld_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int POS_BITS    = 6;
    localparam int START_BITS  = 7;

    localparam int WINDOW_PIXELS_DEF = 61;
    localparam int LINE_PIXELS_DEF   = 128;

    localparam logic [SAMPLE_BITS-1:0] STRETCH_FULL = 12'd4095;

    localparam logic [START_BITS-1:0]  LEFT_START_RST  = 7'd34;
    localparam logic [START_BITS-1:0]  RIGHT_START_RST = 7'd34;
    localparam logic [SAMPLE_BITS-1:0] DARK_THR_RST    = 12'd2500;
    localparam logic [SAMPLE_BITS-1:0] LINE_THR_RST    = 12'd500;

    // configuration register indexes
    localparam logic [1:0] CFG_LEFT_START  = 2'd0;
    localparam logic [1:0] CFG_RIGHT_START = 2'd1;
    localparam logic [1:0] CFG_DARK_THR    = 2'd2;
    localparam logic [1:0] CFG_LINE_THR    = 2'd3;

    // road classification codes
    localparam logic [1:0] ROAD_BOTH  = 2'd0;
    localparam logic [1:0] ROAD_LEFT  = 2'd1;
    localparam logic [1:0] ROAD_RIGHT = 2'd2;
    localparam logic [1:0] ROAD_NONE  = 2'd3;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] left_sample;
        logic [SAMPLE_BITS-1:0] right_sample;
        logic                   end_of_line;
    } t_in_word;

    typedef struct packed {
        logic [1:0]             road_state;
        logic [POS_BITS-1:0]    left_line_pos;
        logic [POS_BITS-1:0]    right_line_pos;
        logic                   left_found;
        logic                   right_found;
        logic [SAMPLE_BITS-1:0] left_dark_min;
        logic [SAMPLE_BITS-1:0] right_dark_min;
    } t_out_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_STRETCH,
        ST_DIV,
        ST_UPDATE,
        ST_RESULT
    } t_state;

endpackage

### hdl/line_scan_lane_detect.sv
`timescale 1ns / 1ps

// Line-scan lane detector. Left/right pixel pairs are taken one word per cycle
// while the block is idle; pixels inside each camera window go to a window
// memory and update the running dark minimum and maximum. The word that marks
// end of line starts a sweep over both windows (left, then right) during which
// the input is not ready: each stored pixel passes through the read, stretch and
// update states, plus the shared bit-serial divider when it lies strictly
// between min and max. The result sits in an output register, so the next line
// may begin while it waits to be taken. No clearing pass after reset.
module line_scan_lane_detect #(
    parameter int WINDOW_PIXELS = lsld_pkg::WINDOW_PIXELS_DEF,
    parameter int LINE_PIXELS   = lsld_pkg::LINE_PIXELS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  lsld_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output lsld_pkg::t_out_word o_out_word,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [11:0]         i_cfg_data
);
    import lsld_pkg::*;

    localparam int IW = (WINDOW_PIXELS > 1) ? $clog2(WINDOW_PIXELS) : 1;
    localparam int PW = $clog2(LINE_PIXELS + 1);
    localparam int CW = (PW > 8) ? PW : 8;
    localparam int SB = SAMPLE_BITS;

    // configuration
    logic [START_BITS-1:0] r_left_start, r_right_start;
    logic [SB-1:0]         r_dark_thr, r_line_thr;

    // control
    t_state         r_state, n_state;
    logic [PW-1:0]  r_pix_pos;
    logic [SB-1:0]  r_left_min, r_left_max, r_right_min, r_right_max;
    logic [POS_BITS-1:0] r_left_pos, r_right_pos;
    logic           r_left_found, r_right_found;
    logic           r_side;
    logic [IW-1:0]  r_idx;
    logic [3:0]     r_bit;
    logic           r_out_valid;
    t_out_word      r_out_word;

    // datapath payload
    logic [SB-1:0]  r_left_mem  [WINDOW_PIXELS];
    logic [SB-1:0]  r_right_mem [WINDOW_PIXELS];
    logic [SB-1:0]  r_left_rd, r_right_rd;
    logic [SB-1:0]  r_rem, r_num_lo, r_val, r_best;

    logic           in_ready, accept, rd_en, sweep_last, pix_take, out_load;
    logic           left_in_win, right_in_win;
    logic [CW-1:0]  pos_c, left_off, right_off;
    logic [SB-1:0]  cur_p, cur_min, cur_max, den, diff;
    logic [2*SB-1:0] num;
    logic [SB:0]    trial;
    logic           trial_ge, qualifies;
    logic           ldark, rdark;
    logic [1:0]     road;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && i_in_word.end_of_line) n_state = ST_READ;
            end
            ST_READ: n_state = ST_STRETCH;
            ST_STRETCH: begin
                if (cur_max <= cur_min || cur_p <= cur_min || cur_p >= cur_max) begin
                    n_state = ST_UPDATE;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_bit == 4'd0) n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (sweep_last && r_side) n_state = ST_RESULT;
                else n_state = ST_READ;
            end
            ST_RESULT: begin
                if (!r_out_valid || i_out_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------- state outputs ----------------
    always_comb begin
        in_ready = 1'b0;
        rd_en    = 1'b0;
        case (r_state)
            ST_IDLE: in_ready = 1'b1;
            ST_READ: rd_en = 1'b1;
            default: begin
                in_ready = 1'b0;
                rd_en    = 1'b0;
            end
        endcase
    end

    assign o_in_ready  = in_ready;
    assign accept      = i_in_valid && in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign out_load    = (r_state == ST_RESULT) && (!r_out_valid || i_out_ready);

    // ---------------- pixel intake ----------------
    assign pos_c        = CW'(r_pix_pos);
    assign left_off     = pos_c - CW'(r_left_start);
    assign right_off    = pos_c - CW'(r_right_start);
    assign pix_take     = accept && (r_pix_pos < PW'(LINE_PIXELS));
    assign left_in_win  = (pos_c >= CW'(r_left_start)) && (left_off < CW'(WINDOW_PIXELS));
    assign right_in_win = (pos_c >= CW'(r_right_start)) && (right_off < CW'(WINDOW_PIXELS));

    always_ff @(posedge i_clk) begin
        if (pix_take && left_in_win) begin
            r_left_mem[left_off[IW-1:0]] <= i_in_word.left_sample;
        end
        if (pix_take && right_in_win) begin
            r_right_mem[right_off[IW-1:0]] <= i_in_word.right_sample;
        end
        if (rd_en) begin
            r_left_rd  <= r_left_mem[r_idx];
            r_right_rd <= r_right_mem[r_idx];
        end
    end

    // ---------------- stretch datapath ----------------
    assign cur_p   = r_side ? r_right_rd  : r_left_rd;
    assign cur_min = r_side ? r_right_min : r_left_min;
    assign cur_max = r_side ? r_right_max : r_left_max;
    assign den     = cur_max - cur_min;
    assign diff    = cur_p - cur_min;
    // 4095*d as (d << 12) - d
    assign num     = {diff, {SB{1'b0}}} - {{SB{1'b0}}, diff};
    assign trial    = {r_rem, r_num_lo[SB-1]};
    assign trial_ge = trial >= {1'b0, den};

    assign qualifies  = (r_val < r_line_thr) && (r_val < r_best);
    assign sweep_last = (r_idx == IW'(WINDOW_PIXELS - 1));

    assign ldark = r_left_min < r_dark_thr;
    assign rdark = r_right_min < r_dark_thr;
    always_comb begin
        if (ldark && rdark) road = ROAD_BOTH;
        else if (ldark)     road = ROAD_LEFT;
        else if (rdark)     road = ROAD_RIGHT;
        else                road = ROAD_NONE;
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: r_best <= STRETCH_FULL;
            ST_STRETCH: begin
                if (cur_max <= cur_min || cur_p >= cur_max) begin
                    r_val <= STRETCH_FULL;
                end else if (cur_p <= cur_min) begin
                    r_val <= '0;
                end else begin
                    // quotient fits 12 bits, so the top half is already below den
                    r_rem    <= num[2*SB-1:SB];
                    r_num_lo <= num[SB-1:0];
                end
            end
            ST_DIV: begin
                r_rem    <= trial_ge ? SB'(trial - {1'b0, den}) : trial[SB-1:0];
                r_num_lo <= {r_num_lo[SB-2:0], 1'b0};
                r_val    <= {r_val[SB-2:0], trial_ge};
            end
            ST_UPDATE: begin
                if (sweep_last) begin
                    r_best <= STRETCH_FULL;
                end else if (qualifies) begin
                    r_best <= r_val;
                end
            end
            default: r_best <= r_best;
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_start  <= LEFT_START_RST;
            r_right_start <= RIGHT_START_RST;
            r_dark_thr    <= DARK_THR_RST;
            r_line_thr    <= LINE_THR_RST;
            r_state       <= ST_IDLE;
            r_pix_pos     <= '0;
            r_left_min    <= STRETCH_FULL;
            r_right_min   <= STRETCH_FULL;
            r_left_max    <= '0;
            r_right_max   <= '0;
            r_left_pos    <= '0;
            r_right_pos   <= '0;
            r_left_found  <= 1'b0;
            r_right_found <= 1'b0;
            r_side        <= 1'b0;
            r_idx         <= '0;
            r_bit         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LEFT_START:  r_left_start  <= i_cfg_data[START_BITS-1:0];
                    CFG_RIGHT_START: r_right_start <= i_cfg_data[START_BITS-1:0];
                    CFG_DARK_THR:    r_dark_thr    <= i_cfg_data;
                    CFG_LINE_THR:    r_line_thr    <= i_cfg_data;
                    default:         r_dark_thr    <= r_dark_thr;
                endcase
            end

            if (out_load) r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;

            if (pix_take) begin
                r_pix_pos <= r_pix_pos + PW'(1);
                if (left_in_win) begin
                    if (i_in_word.left_sample < r_dark_thr && i_in_word.left_sample < r_left_min)
                        r_left_min <= i_in_word.left_sample;
                    if (i_in_word.left_sample > r_left_max)
                        r_left_max <= i_in_word.left_sample;
                end
                if (right_in_win) begin
                    if (i_in_word.right_sample < r_dark_thr && i_in_word.right_sample < r_right_min)
                        r_right_min <= i_in_word.right_sample;
                    if (i_in_word.right_sample > r_right_max)
                        r_right_max <= i_in_word.right_sample;
                end
            end

            case (r_state)
                ST_IDLE: begin
                    r_side        <= 1'b0;
                    r_idx         <= '0;
                    r_left_found  <= 1'b0;
                    r_right_found <= 1'b0;
                end
                ST_STRETCH: r_bit <= 4'(SB - 1);
                ST_DIV:     r_bit <= r_bit - 4'd1;
                ST_UPDATE: begin
                    if (qualifies) begin
                        if (r_side) begin
                            r_right_pos   <= POS_BITS'(r_idx);
                            r_right_found <= 1'b1;
                        end else begin
                            r_left_pos   <= POS_BITS'(r_idx);
                            r_left_found <= 1'b1;
                        end
                    end
                    if (sweep_last) begin
                        r_idx  <= '0;
                        r_side <= 1'b1;
                    end else begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                ST_RESULT: begin
                    if (out_load) begin
                        r_pix_pos   <= '0;
                        r_left_min  <= STRETCH_FULL;
                        r_right_min <= STRETCH_FULL;
                        r_left_max  <= '0;
                        r_right_max <= '0;
                    end
                end
                default: r_side <= r_side;
            endcase
        end
    end

    // result word, loaded once the output register is free
    always_ff @(posedge i_clk) begin
        if (r_state == ST_RESULT && (!r_out_valid || i_out_ready)) begin
            r_out_word.road_state     <= road;
            r_out_word.left_line_pos  <= r_left_pos;
            r_out_word.right_line_pos <= r_right_pos;
            r_out_word.left_found     <= r_left_found;
            r_out_word.right_found    <= r_right_found;
            r_out_word.left_dark_min  <= r_left_min;
            r_out_word.right_dark_min <= r_right_min;
        end
    end

endmodule
